>>> rtl/drs_pkg.sv
// Package: shared types and constants for the disk request scheduler.
`default_nettype none
package drs_pkg;
   localparam logic CMD_ARRIVE   = 1'b0;
   localparam logic CMD_COMPLETE = 1'b1;

   localparam logic [1:0] POLICY_FCFS = 2'd0;
   localparam logic [1:0] POLICY_SSTF = 2'd1;
   localparam logic [1:0] POLICY_LOOK = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_POLICY = 3'd0;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] arr_time;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] process;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load_cmd;      // capture input beat
      logic to_current;    // arrival straight into service
      logic append;        // write arrival at tail
      logic scan_clear;    // begin selection sweep
      logic scan_step;     // evaluate one slot
      logic take;          // move picked entry into current
      logic shift_step;    // close gap by one slot
      logic go_idle;       // empty-queue completion
      logic emit;          // drive result strobe
      logic set_full;      // dropped arrival
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic cmd;
      logic cur_valid;
      logic queue_empty;
      logic queue_full;
      logic scan_last;
      logic shift_done;
   } sts_type;
endpackage
`default_nettype wire

>>> rtl/drs_datapath.sv
// Datapath: pending queue memory, current request, selection sweep, shifter.
`default_nettype none
module drs_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire drs_pkg::ctl_type  ctl,
   output drs_pkg::sts_type       sts,
   input  wire logic [1:0]        policy,
   input  wire logic              in_cmd,
   input  wire drs_pkg::entry_type in_entry,
   input  wire logic [15:0]       in_head,
   input  wire logic              in_dir,
   output logic                   out_strobe,
   output logic                   out_valid,
   output drs_pkg::entry_type     out_entry,
   output logic [4:0]             out_count,
   output logic                   out_full
);
   import drs_pkg::*;
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_ff;
   logic [CW-1:0] total_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmd_ff, dir_ff;
   entry_type     arr_ff;
   logic [15:0]   head_ff;
   logic          cur_valid_ff;
   entry_type     cur_ff;
   logic          strobe_ff, full_ff;
   // best-so-far: rank (class, dist, time) and slot
   logic [IW-1:0] best_ff;
   logic          found_ff;
   logic [1:0]    bcls_ff;
   logic [15:0]   bdist_ff;
   logic [31:0]   btime_ff;
   logic          rd_ok_ff;
   logic          sh_ok_ff;
   logic [CW-1:0] rd_idx_ff;

   logic [15:0] seek_dist;
   logic [1:0]  cls;
   logic        better;
   logic [IW-1:0] rd_addr;

   always_comb begin
      seek_dist = (head_ff >= rd_ff.cylinder) ? head_ff - rd_ff.cylinder
                                              : rd_ff.cylinder - head_ff;
      // LOOK class: 0 same cylinder, 1 ahead, 2 other
      if (rd_ff.cylinder == head_ff) cls = 2'd0;
      else if (dir_ff ? (rd_ff.cylinder > head_ff) : (rd_ff.cylinder < head_ff))
         cls = 2'd1;
      else cls = 2'd2;
      case (policy)
         POLICY_SSTF: better = (seek_dist < bdist_ff) ||
                               (seek_dist == bdist_ff && rd_ff.arr_time < btime_ff);
         POLICY_LOOK: begin
            if (cls != bcls_ff) better = cls < bcls_ff;
            else if (cls == 2'd0) better = rd_ff.arr_time < btime_ff;
            else better = seek_dist < bdist_ff;
         end
         default: better = rd_ff.arr_time < btime_ff;
      endcase
      better = better || !found_ff;
      rd_addr = idx_ff[IW-1:0];
      if (ctl.shift_step) rd_addr = IW'(idx_ff + 1'b1);
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.scan_clear) idx_in = '0;
      else if (ctl.scan_step) idx_in = idx_ff + 1'b1;
      else if (ctl.take) idx_in = CW'(best_ff);
      else if (ctl.shift_step) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      rd_ff     <= mem_ff[rd_addr];
      rd_idx_ff <= idx_ff;
      if (ctl.append) mem_ff[total_ff[IW-1:0]] <= arr_ff;
      if (sh_ok_ff) mem_ff[rd_idx_ff[IW-1:0]] <= rd_ff;
      if (ctl.load_cmd) begin
         cmd_ff <= in_cmd; arr_ff <= in_entry; head_ff <= in_head; dir_ff <= in_dir;
      end
      if (ctl.to_current) cur_ff <= arr_ff;
      if (ctl.take) cur_ff <= mem_ff[best_ff];
      if (ctl.go_idle) cur_ff <= '0;
      if (rd_ok_ff && better) begin
         best_ff <= rd_idx_ff[IW-1:0]; bcls_ff <= cls;
         bdist_ff <= seek_dist; btime_ff <= rd_ff.arr_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0; cur_valid_ff <= 1'b0; strobe_ff <= 1'b0; full_ff <= 1'b0;
         idx_ff <= '0; found_ff <= 1'b0; rd_ok_ff <= 1'b0; sh_ok_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         strobe_ff <= ctl.emit;
         rd_ok_ff  <= ctl.scan_step;
         sh_ok_ff  <= ctl.shift_step;
         if (ctl.scan_clear) found_ff <= 1'b0;
         else if (rd_ok_ff) found_ff <= 1'b1;
         if (ctl.load_cmd) full_ff <= 1'b0;
         if (ctl.set_full) full_ff <= 1'b1;
         if (ctl.to_current || ctl.take) cur_valid_ff <= 1'b1;
         if (ctl.go_idle) cur_valid_ff <= 1'b0;
         if (ctl.append) total_ff <= total_ff + 1'b1;
         if (ctl.take) total_ff <= total_ff - 1'b1;
      end
   end

   // shift: slot idx+1 is read into a register, then written one slot lower in the cycle after
   always_comb begin
      sts.cmd         = cmd_ff;
      sts.cur_valid   = cur_valid_ff;
      sts.queue_empty = (total_ff == '0);
      sts.queue_full  = (total_ff == CW'(QUEUE_DEPTH));
      sts.scan_last   = (idx_ff == total_ff - 1'b1);
      sts.shift_done  = (idx_ff >= total_ff);
      out_strobe = strobe_ff;
      out_valid  = cur_valid_ff;
      out_entry  = cur_ff;
      out_count  = 5'(total_ff);
      out_full   = full_ff;
   end
endmodule
`default_nettype wire

>>> rtl/drs_controller.sv
// Controller: sequences arrival, selection sweep, removal shift and result.
`default_nettype none
module drs_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire drs_pkg::sts_type sts,
   output drs_pkg::ctl_type      ctl
);
   import drs_pkg::*;
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_TAKE, S_PRIME, S_SHIFT, S_EMIT
   } state_type;
   state_type state_ff;

   always_comb begin
      ctl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:  ctl.load_cmd = start;
         S_DECODE: begin
            if (sts.cmd == CMD_ARRIVE) begin
               if (!sts.cur_valid) ctl.to_current = 1'b1;
               else if (!sts.queue_full) ctl.append = 1'b1;
               else ctl.set_full = 1'b1;
            end else if (sts.queue_empty) ctl.go_idle = 1'b1;
            else ctl.scan_clear = 1'b1;
         end
         S_SCAN:  ctl.scan_step = 1'b1;
         S_TAKE:  ctl.take = 1'b1;
         S_PRIME: ctl.shift_step = !sts.shift_done;
         S_SHIFT: ctl.shift_step = !sts.shift_done;
         S_EMIT:  ctl.emit = 1'b1;
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else begin
         case (state_ff)
            S_IDLE:   if (start) state_ff <= S_DECODE;
            S_DECODE: state_ff <= (sts.cmd == CMD_COMPLETE && !sts.queue_empty)
                                  ? S_SCAN : S_EMIT;
            S_SCAN:   if (sts.scan_last) state_ff <= S_DRAIN;
            S_DRAIN:  state_ff <= S_TAKE;
            S_TAKE:   state_ff <= S_PRIME;
            S_PRIME:  state_ff <= S_SHIFT;
            S_SHIFT:  if (sts.shift_done) state_ff <= S_EMIT;
            S_EMIT:   state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/disk_request_scheduler.sv
// Top level: disk request scheduler with FCFS, SSTF and LOOK selection.
//
// Usage:
//  - Input beat: accepted when start is high and busy is low.
//    req_command 0 is an arrival (id, time, cylinder, address, process),
//    1 is a completion (req_head_cylinder, req_scan_direction used).
//  - Result beat: one per input beat, rsp_strobe high for one cycle with
//    the request now in service, the queue occupancy and the drop flag.
//    The receiver cannot stall; the beat is gone after that cycle.
//  - Policy register at byte 0 of the APB port, writes while idle.
// Sequence: an arrival or an empty-queue completion passes DECODE and EMIT,
//  and the strobe is registered from EMIT; a completion with queued entries
//  steps one slot per cycle through the queue memory read port for the
//  selection sweep, then passes DRAIN, TAKE and PRIME, then closes the gap
//  one slot per cycle, then the strobe.
// Throughput: one beat at a time; busy drops during the strobe cycle, so
//  the next beat can be taken at the edge that ends it.
// Reset: queue empty, disk idle, policy FCFS. Queue contents are not
//  cleared; only slots below the fill count are ever read.
`default_nettype none
module disk_request_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [15:0] req_request_id,
   input  wire logic [31:0] req_arrival_time,
   input  wire logic [15:0] req_cylinder,
   input  wire logic [31:0] req_block_address,
   input  wire logic [15:0] req_process_id,
   input  wire logic [15:0] req_head_cylinder,
   input  wire logic        req_scan_direction,
   output logic             rsp_strobe,
   output logic             rsp_serving_valid,
   output logic [15:0]      rsp_serving_id,
   output logic [31:0]      rsp_serving_time,
   output logic [15:0]      rsp_serving_cylinder,
   output logic [31:0]      rsp_serving_address,
   output logic [15:0]      rsp_serving_process,
   output logic [4:0]       rsp_pending_count,
   output logic             rsp_queue_full,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [drs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import drs_pkg::*;
   ctl_type   ctl;
   sts_type   sts;
   entry_type in_entry, out_entry;
   logic [1:0] policy_ff;

   // config register: policy, low two bits kept
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) policy_ff <= POLICY_FCFS;
      else if (psel && penable && pwrite && paddr == CSR_POLICY)
         policy_ff <= pwdata[1:0];
   end
   assign prdata = (paddr == CSR_POLICY) ? {30'd0, policy_ff} : 32'd0;

   assign in_entry = '{id: req_request_id, arr_time: req_arrival_time,
                       cylinder: req_cylinder, address: req_block_address,
                       process: req_process_id};

   drs_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .ctl(ctl));

   drs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts), .policy(policy_ff),
      .in_cmd(req_command), .in_entry(in_entry), .in_head(req_head_cylinder),
      .in_dir(req_scan_direction), .out_strobe(rsp_strobe),
      .out_valid(rsp_serving_valid), .out_entry(out_entry),
      .out_count(rsp_pending_count), .out_full(rsp_queue_full));

   assign rsp_serving_id       = out_entry.id;
   assign rsp_serving_time     = out_entry.arr_time;
   assign rsp_serving_cylinder = out_entry.cylinder;
   assign rsp_serving_address  = out_entry.address;
   assign rsp_serving_process  = out_entry.process;

   // a result beat only while a command is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without command");
   // a dropped arrival leaves the disk serving
   a_full_serving: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_queue_full |-> rsp_serving_valid)
      else $error("drop while idle");
   // an idle disk reports an empty queue
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_serving_valid |-> rsp_pending_count == 5'd0)
      else $error("idle with queue");
endmodule
`default_nettype wire

>>> test/disk_request_scheduler_tb.sv
// Testbench: disk request scheduler, predicted against an in-bench queue model.
module disk_request_scheduler_tb;
   import drs_pkg::*;

   localparam int DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] POLICY_SPARE = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [15:0] id;
      logic [31:0] arr_time;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] process;
      logic [15:0] head;
      logic        dir_up;
   } beat_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] id;
      logic [31:0] arr_time;
      logic [15:0] cylinder;
      logic [31:0] address;
      logic [15:0] process;
      logic [4:0]  count;
      logic        full;
   } serving_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_command = 1'b0;
   logic [15:0] req_request_id = '0;
   logic [31:0] req_arrival_time = '0;
   logic [15:0] req_cylinder = '0;
   logic [31:0] req_block_address = '0;
   logic [15:0] req_process_id = '0;
   logic [15:0] req_head_cylinder = '0;
   logic req_scan_direction = 1'b0;
   logic rsp_strobe, rsp_serving_valid, rsp_queue_full;
   logic [15:0] rsp_serving_id, rsp_serving_cylinder, rsp_serving_process;
   logic [31:0] rsp_serving_time, rsp_serving_address;
   logic [4:0] rsp_pending_count;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   disk_request_scheduler uut (
      .clock, .reset, .start, .busy,
      .req_command, .req_request_id, .req_arrival_time, .req_cylinder,
      .req_block_address, .req_process_id, .req_head_cylinder, .req_scan_direction,
      .rsp_strobe, .rsp_serving_valid, .rsp_serving_id, .rsp_serving_time,
      .rsp_serving_cylinder, .rsp_serving_address, .rsp_serving_process,
      .rsp_pending_count, .rsp_queue_full,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always #6 clock = ~clock;

   // Predictor state: the queue, the request in service and the policy.
   entry_type   queue_model[$];
   entry_type   serving_model;
   logic        serving_live;
   logic [1:0]  policy_model;

   beat_type    beat_queue[$];     // stimulus waiting for the driver
   serving_type expected_queue[$]; // predicted results in order

   int failures = 0;
   int cycles = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int drops_seen = 0;
   int nulls_seen = 0;
   int send_idle_pct = 16;

   function automatic logic [15:0] seek(logic [15:0] head, logic [15:0] cyl);
      return (head >= cyl) ? head - cyl : cyl - head;
   endfunction

   // Index of the queued entry a completion takes under the current policy.
   function automatic int choose_slot(logic [15:0] head, logic dir_up);
      int best;
      logic found;
      logic [15:0] bd, d;
      best = 0;
      found = 1'b0;
      bd = '0;
      if (policy_model == POLICY_SSTF) begin
         bd = seek(head, queue_model[0].cylinder);
         for (int i = 1; i < queue_model.size(); i++) begin
            d = seek(head, queue_model[i].cylinder);
            if (d < bd || (d == bd && queue_model[i].arr_time < queue_model[best].arr_time)) begin
               best = i;
               bd = d;
            end
         end
      end else if (policy_model == POLICY_LOOK) begin
         // same cylinder first, then nearest in the sweep direction, then nearest overall
         for (int i = 0; i < queue_model.size(); i++)
            if (queue_model[i].cylinder == head &&
                (!found || queue_model[i].arr_time < queue_model[best].arr_time)) begin
               best = i;
               found = 1'b1;
            end
         if (!found)
            for (int i = 0; i < queue_model.size(); i++) begin
               d = seek(head, queue_model[i].cylinder);
               if ((dir_up ? queue_model[i].cylinder > head : queue_model[i].cylinder < head)
                   && (!found || d < bd)) begin
                  best = i;
                  bd = d;
                  found = 1'b1;
               end
            end
         if (!found)
            for (int i = 0; i < queue_model.size(); i++) begin
               d = seek(head, queue_model[i].cylinder);
               if (!found || d < bd) begin
                  best = i;
                  bd = d;
                  found = 1'b1;
               end
            end
      end else begin
         // FCFS, also for the unused policy code
         for (int i = 1; i < queue_model.size(); i++)
            if (queue_model[i].arr_time < queue_model[best].arr_time)
               best = i;
      end
      return best;
   endfunction

   function automatic serving_type advance_scheduler(beat_type b);
      serving_type r;
      entry_type e;
      int k;
      logic dropped;
      dropped = 1'b0;
      if (b.cmd == CMD_ARRIVE) begin
         e = '{id: b.id, arr_time: b.arr_time, cylinder: b.cylinder,
               address: b.address, process: b.process};
         if (!serving_live) begin
            serving_live = 1'b1;
            serving_model = e;
         end else if (queue_model.size() < DEPTH)
            queue_model.push_back(e);
         else
            dropped = 1'b1;
      end else if (queue_model.size() == 0) begin
         serving_live = 1'b0;
         serving_model = '0;
      end else begin
         k = choose_slot(b.head, b.dir_up);
         serving_model = queue_model[k];
         serving_live = 1'b1;
         queue_model.delete(k);
      end
      r.valid = serving_live;
      r.id = serving_live ? serving_model.id : '0;
      r.arr_time = serving_live ? serving_model.arr_time : '0;
      r.cylinder = serving_live ? serving_model.cylinder : '0;
      r.address = serving_live ? serving_model.address : '0;
      r.process = serving_live ? serving_model.process : '0;
      r.count = 5'(queue_model.size());
      r.full = dropped;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      failures++;
      $display("mismatch at beat %0d: %s got %0h expected %0h", beats_checked, what, got, want);
   endtask

   // Acceptance tracking at the rising edge.
   logic taken_last = 1'b0;
   always @(posedge clock) begin
      taken_last <= start && !busy && !reset;
   end

   // Driver: one beat at a time, held until the block takes it.
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || taken_last) begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_type b;
               b = beat_queue.pop_front();
               start <= 1'b1;
               req_command <= b.cmd;
               req_request_id <= b.id;
               req_arrival_time <= b.arr_time;
               req_cylinder <= b.cylinder;
               req_block_address <= b.address;
               req_process_id <= b.process;
               req_head_cylinder <= b.head;
               req_scan_direction <= b.dir_up;
               expected_queue.push_back(advance_scheduler(b));
               beats_sent++;
            end else
               start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is matched against the oldest prediction.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_strobe) begin
         if (expected_queue.size() == 0) begin
            report_mismatch("unpredicted beat id", 32'(rsp_serving_id), 32'd0);
         end else begin
            serving_type w;
            w = expected_queue.pop_front();
            if (rsp_serving_valid !== w.valid)
               report_mismatch("valid", 32'(rsp_serving_valid), 32'(w.valid));
            if (rsp_serving_id !== w.id)
               report_mismatch("id", 32'(rsp_serving_id), 32'(w.id));
            if (rsp_serving_time !== w.arr_time)
               report_mismatch("time", rsp_serving_time, w.arr_time);
            if (rsp_serving_cylinder !== w.cylinder)
               report_mismatch("cylinder", 32'(rsp_serving_cylinder), 32'(w.cylinder));
            if (rsp_serving_address !== w.address)
               report_mismatch("address", rsp_serving_address, w.address);
            if (rsp_serving_process !== w.process)
               report_mismatch("process", 32'(rsp_serving_process), 32'(w.process));
            if (rsp_pending_count !== w.count)
               report_mismatch("count", 32'(rsp_pending_count), 32'(w.count));
            if (rsp_queue_full !== w.full)
               report_mismatch("full", 32'(rsp_queue_full), 32'(w.full));
            if (w.full) drops_seen++;
            if (!w.valid) nulls_seen++;
            beats_checked++;
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic beat_type arrival(logic [15:0] id, logic [31:0] t, logic [15:0] cyl,
                                        logic [31:0] a, logic [15:0] p);
      beat_type b;
      b = '0;
      b.cmd = CMD_ARRIVE;
      b.id = id; b.arr_time = t; b.cylinder = cyl; b.address = a; b.process = p;
      // head and direction are don't-care on arrivals, but keep them toggling
      b.head = 16'($urandom);
      b.dir_up = 1'($urandom);
      return b;
   endfunction

   function automatic beat_type completion(logic [15:0] head, logic dir_up);
      beat_type b;
      b = '0;
      b.cmd = CMD_COMPLETE;
      // request fields are don't-care on completions, but keep them toggling
      b.id = 16'($urandom);
      b.arr_time = $urandom;
      b.cylinder = 16'($urandom);
      b.address = $urandom;
      b.process = 16'($urandom);
      b.head = head;
      b.dir_up = dir_up;
      return b;
   endfunction

   // Random arrival; small cylinder/time pools give plenty of ties.
   function automatic beat_type random_arrival();
      logic [15:0] cyl;
      logic [31:0] t;
      cyl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8) * 4 + 100);
      t = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20));
      return arrival(16'($urandom), t, cyl, $urandom, 16'($urandom));
   endfunction

   function automatic beat_type random_completion();
      logic [15:0] head;
      head = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40) + 98);
      return completion(head, 1'($urandom));
   endfunction

   task automatic wait_drained();
      while (beat_queue.size() != 0 || expected_queue.size() != 0 || start)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // Register write: setup then access phase, changes on falling edges.
   task automatic write_policy(logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_POLICY; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      policy_model = value[1:0];
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // Random phase: bursts of arrivals, then a random number of completions.
   task automatic random_phase(int n);
      int made;
      made = 0;
      while (made < n) begin
         int burst;
         int drain;
         burst = $urandom_range(20, 1);
         drain = $urandom_range(burst + 2);
         for (int i = 0; i < burst; i++) beat_queue.push_back(random_arrival());
         for (int i = 0; i < drain; i++)
            beat_queue.push_back(random_completion());
         made += burst + drain;
      end
      wait_drained();
   endtask

   initial begin
      logic [1:0] policies [6];
      policies = '{POLICY_SSTF, POLICY_LOOK, POLICY_SPARE, POLICY_FCFS, POLICY_LOOK,
                   POLICY_SSTF};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: completion while idle, all-zero request, extremes, fill to drop.
      beat_queue.push_back(completion(16'hFFFF, 1'b1));
      beat_queue.push_back(arrival('0, '0, '0, '0, '0));
      beat_queue.push_back(arrival('1, '1, '1, '1, '1));
      for (int i = 0; i < 16; i++)
         beat_queue.push_back(arrival(16'(i), 32'(20 - i), 16'(i * 4000), $urandom, 16'(i)));
      beat_queue.push_back(arrival(16'hAAAA, 32'h5555_5555, 16'h5555, 32'hAAAA_AAAA, 16'hAAAA));
      for (int i = 0; i < 3; i++) beat_queue.push_back(completion(16'd30000, 1'b0));
      wait_drained();

      foreach (policies[p]) begin
         write_policy({30'h0, policies[p]});
         // LOOK special cases: same-cylinder ties, nothing ahead in the sweep
         beat_queue.push_back(arrival(16'd1, 32'd9, 16'd500, 32'd0, 16'd0));
         beat_queue.push_back(arrival(16'd2, 32'd5, 16'd500, 32'd1, 16'd1));
         beat_queue.push_back(arrival(16'd3, 32'd5, 16'd500, 32'd2, 16'd2));
         beat_queue.push_back(arrival(16'd4, 32'd1, 16'd490, 32'd3, 16'd3));
         beat_queue.push_back(arrival(16'd5, 32'd2, 16'd510, 32'd4, 16'd4));
         beat_queue.push_back(completion(16'd500, 1'b1));
         beat_queue.push_back(completion(16'd600, 1'b1));
         beat_queue.push_back(completion(16'd0, 1'b0));
         beat_queue.push_back(completion(16'd500, 1'b1));
         beat_queue.push_back(completion(16'd500, 1'b0));
         beat_queue.push_back(completion(16'd500, 1'b0));
         case (p)
            2: send_idle_pct = 76;
            4: send_idle_pct = 0;
            default: ;
         endcase
         random_phase(100);
      end

      $display("checked %0d result beats over %0d sent, %0d drops, %0d null results",
               beats_checked, beats_sent, drops_seen, nulls_seen);
      $display("policies exercised: FCFS, SSTF, LOOK and the unused code");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

>>> files.f
rtl/drs_pkg.sv
rtl/drs_datapath.sv
rtl/drs_controller.sv
rtl/disk_request_scheduler.sv
test/disk_request_scheduler_tb.sv
